FILE: rtl/bsa_pkg.sv
// Shared types, constants and helpers for the bitmap slot allocator.
// No dependencies; compiled first.
package bsa_pkg;

  localparam int WORD_BITS     = 64;
  localparam int MAP_WORDS_DEF = 16;
  localparam int WIU_W         = 5;
  localparam int IDX_W         = 10;
  localparam int POS_W         = 6;
  localparam int WIU_RESET     = 16;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  // register index, taken from paddr[2]
  localparam logic REG_WORDS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    REQ_ACQ_FRONT = 2'd0,
    REQ_ACQ_BACK  = 2'd1,
    REQ_RELEASE   = 2'd2,
    REQ_RESET     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [POS_W-1:0] pos;
  } scan_res_t;

  // position, counted from the MSB, of the leading one of a 16-bit group
  function automatic logic [3:0] lead16(input logic [15:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        p = 4'(15 - i);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/bsa_req_if.sv
// Request channel: valid/ready plus request payload.
// Depends on bsa_pkg.
interface bsa_req_if;
  logic                    valid;
  logic                    ready;
  bsa_pkg::req_type_t      req_type;
  logic [bsa_pkg::IDX_W-1:0] release_index;

  modport source (output valid, req_type, release_index, input ready);
  modport sink   (input valid, req_type, release_index, output ready);
endinterface

FILE: rtl/bsa_rsp_if.sv
// Result channel: valid/ready plus result payload.
// Depends on bsa_pkg.
interface bsa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bsa_pkg::IDX_W-1:0] slot_index;
  bsa_pkg::status_t          status;

  modport source (output valid, slot_index, status, input ready);
  modport sink   (input valid, slot_index, status, output ready);
endinterface

FILE: rtl/bitmap_slot_allocator.sv
// Bitmap slot allocator top level: free map memory, summary bits, sequencer.
// Depends on bsa_pkg, bsa_req_if, bsa_rsp_if and bsa_scan.
// Acquire makes two passes of the 16-bit-per-cycle leading-one unit (word
//   summary, then the chosen word) plus one map read; release reads the
//   map word unless out of range; reset answers directly.
// One item in flight; the next is taken the cycle after the result beat.
// rst_n (sync): all words free, words_in_use = min(16, MAP_WORDS, 31).
module bitmap_slot_allocator #(
  parameter int MAP_WORDS = bsa_pkg::MAP_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bsa_req_if.sink                     in_req,
  bsa_rsp_if.source                   out_rsp,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bsa_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [bsa_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [bsa_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import bsa_pkg::*;

  localparam int UW = (MAP_WORDS > 31) ? 31 : MAP_WORDS;
  localparam int AW = (UW > 1) ? $clog2(UW) : 1;
  localparam logic [WIU_W-1:0] WIU_MAX = WIU_W'(UW);
  localparam logic [WIU_W-1:0] WIU_RST =
    (WIU_RESET > UW) ? WIU_W'(UW) : WIU_W'(WIU_RESET);
  localparam logic [POS_W-1:0] UW_M1 = POS_W'(UW - 1);
  localparam logic [WORD_BITS-1:0] MSB_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_WSCAN, S_BREAD, S_BSCAN, S_RREAD, S_OUT
  } state_t;

  state_t               state_r;
  req_type_t            req_r;
  logic [IDX_W-1:0]     rel_r;
  logic [AW-1:0]        word_r;
  logic [WORD_BITS-1:0] data_r;
  logic [IDX_W-1:0]     slot_r;
  status_t              status_r;
  logic [WIU_W-1:0]     wiu_r;
  logic [UW-1:0]        valid_r;
  logic [UW-1:0]        empty_r;

  logic [WORD_BITS-1:0] mem_r [UW];
  logic [WORD_BITS-1:0] rd_data_r;

  logic                 accept;
  logic                 cfg_wr;
  logic [WIU_W-1:0]     cfg_n;
  logic [UW-1:0]        cand;
  logic [WORD_BITS-1:0] vec_f;
  logic [WORD_BITS-1:0] vec_b;
  logic                 scan_start;
  logic [WORD_BITS-1:0] scan_vec;
  scan_res_t            scan_res;
  logic [POS_W-1:0]     found_w6;
  logic [AW-1:0]        found_word;
  logic [WIU_W-1:0]     rel_word5;
  logic                 rel_in_range;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] eff_word;
  logic [WORD_BITS-1:0] acq_new;
  logic [WORD_BITS-1:0] rel_bit;
  logic                 rel_already;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [WIU_W-1:0]     word5;

  assign accept = in_req.valid && in_req.ready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[2] == REG_WORDS_IN_USE);
  assign cfg_n  = (cfg_pwdata[WIU_W-1:0] > WIU_MAX) ? WIU_MAX : cfg_pwdata[WIU_W-1:0];

  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_WORDS_IN_USE) begin
      cfg_prdata = CFG_DW'(wiu_r);
    end
  end

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = (state_r == S_OUT);
  assign out_rsp.slot_index = slot_r;
  assign out_rsp.status     = status_r;

  // word summary: nonempty words in use, word 0 at the MSB (front) or last word at the MSB (back)
  always_comb begin
    vec_f = '0;
    vec_b = '0;
    for (int i = 0; i < UW; i++) begin
      cand[i] = !empty_r[i] && (WIU_W'(i) < wiu_r);
    end
    for (int i = 0; i < UW; i++) begin
      vec_f[WORD_BITS-1-i] = cand[i];
      vec_b[WORD_BITS-1-i] = cand[UW-1-i];
    end
  end

  assign scan_start = (state_r == S_BREAD) ||
                      (accept && (in_req.req_type == REQ_ACQ_FRONT ||
                                  in_req.req_type == REQ_ACQ_BACK));
  assign scan_vec   = (state_r == S_BREAD) ? eff_word :
                      (in_req.req_type == REQ_ACQ_BACK) ? vec_b : vec_f;

  bsa_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .vec   (scan_vec),
    .res   (scan_res)
  );

  assign found_w6   = (req_r == REQ_ACQ_BACK) ? (UW_M1 - scan_res.pos) : scan_res.pos;
  assign found_word = found_w6[AW-1:0];

  assign rel_word5    = {1'b0, in_req.release_index[IDX_W-1:POS_W]};
  assign rel_in_range = rel_word5 < wiu_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = found_word;
    if (state_r == S_IDLE) begin
      rd_en   = accept && in_req.req_type == REQ_RELEASE && rel_in_range;
      rd_addr = rel_word5[AW-1:0];
    end else if (state_r == S_WSCAN) begin
      rd_en = scan_res.done && scan_res.found;
    end
  end

  assign eff_word    = valid_r[word_r] ? rd_data_r : '1;
  assign acq_new     = data_r & ~(MSB_BIT >> scan_res.pos);
  assign rel_bit     = MSB_BIT >> rel_r[POS_W-1:0];
  assign rel_already = |(eff_word & rel_bit);
  assign word5       = WIU_W'(word_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = acq_new;
    if (state_r == S_BSCAN) begin
      wr_en = scan_res.done;
    end else if (state_r == S_RREAD) begin
      wr_en   = !rel_already;
      wr_data = eff_word | rel_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[word_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // per-word valid and empty bits; a word that is not valid reads all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      empty_r <= '0;
      wiu_r   <= WIU_RST;
    end else begin
      if (cfg_wr) begin
        wiu_r <= cfg_n;
        for (int i = 0; i < UW; i++) begin
          if (WIU_W'(i) >= wiu_r && WIU_W'(i) < cfg_n) begin
            valid_r[i] <= 1'b0;
            empty_r[i] <= 1'b0;
          end
        end
      end
      if (accept && in_req.req_type == REQ_RESET) begin
        for (int i = 0; i < UW; i++) begin
          if (WIU_W'(i) < wiu_r) begin
            valid_r[i] <= 1'b0;
            empty_r[i] <= 1'b0;
          end
        end
      end
      if (wr_en) begin
        valid_r[word_r] <= 1'b1;
        empty_r[word_r] <= ~|wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r    <= in_req.req_type;
            rel_r    <= in_req.release_index;
            word_r   <= rel_word5[AW-1:0];
            slot_r   <= '0;
            status_r <= ST_OK;
            unique case (in_req.req_type)
              REQ_ACQ_FRONT, REQ_ACQ_BACK: state_r <= S_WSCAN;
              REQ_RELEASE: begin
                if (rel_in_range) begin
                  state_r <= S_RREAD;
                end else begin
                  status_r <= ST_RANGE;
                  state_r  <= S_OUT;
                end
              end
              REQ_RESET: state_r <= S_OUT;
            endcase
          end
        end
        S_WSCAN: begin
          if (scan_res.done) begin
            if (scan_res.found) begin
              word_r  <= found_word;
              state_r <= S_BREAD;
            end else begin
              status_r <= ST_NONE;
              state_r  <= S_OUT;
            end
          end
        end
        S_BREAD: begin
          data_r  <= eff_word;
          state_r <= S_BSCAN;
        end
        S_BSCAN: begin
          if (scan_res.done) begin
            slot_r  <= {word5[IDX_W-POS_W-1:0], scan_res.pos};
            state_r <= S_OUT;
          end
        end
        S_RREAD: begin
          if (rel_already) begin
            status_r <= ST_ALREADY;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_rsp.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_req.ready && out_rsp.valid))
    else $error("request and result sides active together");

  a_word_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BSCAN && scan_res.done) |-> scan_res.found)
    else $error("nonempty word scanned without a free bit");

  a_rel_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && (out_rsp.status == ST_RANGE || out_rsp.status == ST_ALREADY))
    |-> req_r == REQ_RELEASE)
    else $error("range or already-free status on a non-release beat");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && (out_rsp.status != ST_OK || req_r == REQ_RELEASE ||
                       req_r == REQ_RESET)) |-> out_rsp.slot_index == '0)
    else $error("nonzero slot on a beat without an acquired slot");

endmodule

FILE: rtl/bsa_scan.sv
// Shared leading-one search over a 64-bit vector, one 16-bit group per cycle.
// Depends on bsa_pkg.
module bsa_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        vec,
  output bsa_pkg::scan_res_t res
);
  import bsa_pkg::*;

  localparam logic [1:0] LAST_GRP = 2'd3;

  logic        busy_r;
  logic [1:0]  grp_r;
  logic [63:0] vec_r;
  logic [15:0] cur;
  logic        hit;

  assign cur = vec_r[63:48];
  assign hit = |cur;

  always_comb begin
    res.done  = busy_r && (hit || grp_r == LAST_GRP);
    res.found = hit;
    res.pos   = {grp_r, lead16(cur)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      grp_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      grp_r  <= '0;
    end else if (busy_r) begin
      if (res.done) begin
        busy_r <= 1'b0;
      end else begin
        grp_r <= grp_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec_r <= vec;
    end else if (busy_r) begin
      vec_r <= {vec_r[47:0], 16'h0};
    end
  end

endmodule
